// ===== src/apbp_pkg.sv =====
// shared constants, types and controller encodings for the allpass bandpass filter
`default_nettype none

package apbp_pkg;

	localparam int DIGIT_W     = 4;
	localparam int GAIN_W      = 16;
	localparam int GAIN_DIGITS = GAIN_W / DIGIT_W;
	localparam int FRAC_BITS   = 15;
	localparam int CFG_IDX_W   = 2;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

	localparam logic [CFG_IDX_W-1:0] REG_C    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_K    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_BIAS,
		ST_SAT,
		ST_GAIN,
		ST_OUT
	} apbp_state_t;

	typedef struct packed {
		logic idle;
		logic acc_clear;
		logic mac_step;
		logic first_digit;
		logic bias_add;
		logic sat_load;
		logic gain_phase;
		logic out_load;
	} apbp_ctl_t;

endpackage

`default_nettype wire

// ===== src/apbp_digit_mac.sv =====
// two-lane digit-serial multiply-accumulate, most significant digit first
`default_nettype none

module apbp_digit_mac #(
	parameter int OP_W  = 19,
	parameter int ACC_W = 40
) (
	input  wire logic                              clk,
	input  wire apbp_pkg::apbp_ctl_t               ctl,
	input  wire logic [apbp_pkg::DIGIT_W-1:0]      digit_a,
	input  wire logic [apbp_pkg::DIGIT_W-1:0]      digit_b,
	input  wire logic signed [OP_W-1:0]            op_a,
	input  wire logic signed [OP_W-1:0]            op_b,
	input  wire logic signed [ACC_W-1:0]           bias,
	output logic signed [ACC_W-1:0]                acc
);
	import apbp_pkg::*;

	logic signed [DIGIT_W:0]      da_x;
	logic signed [DIGIT_W:0]      db_x;
	logic signed [OP_W+DIGIT_W:0] prod_a;
	logic signed [OP_W+DIGIT_W:0] prod_b;
	logic signed [ACC_W-1:0]      acc_q;

	// top digit of a signed coefficient carries the sign
	assign da_x = ctl.first_digit ? {digit_a[DIGIT_W-1], digit_a} : {1'b0, digit_a};
	assign db_x = ctl.first_digit ? {digit_b[DIGIT_W-1], digit_b} : {1'b0, digit_b};

	assign prod_a = da_x * op_a;
	assign prod_b = db_x * op_b;

	always_ff @(posedge clk) begin
		if (ctl.acc_clear) begin
			acc_q <= '0;
		end else if (ctl.mac_step) begin
			acc_q <= (acc_q <<< DIGIT_W) + ACC_W'(prod_a) + ACC_W'(prod_b);
		end else if (ctl.bias_add) begin
			acc_q <= acc_q + bias;
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

// ===== src/apbp_ctrl.sv =====
// sequencer for the coefficient, rounding, gain and output steps of one sample
`default_nettype none

module apbp_ctrl #(
	parameter int NUM_DIG = 5
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_fire,
	input  wire logic                out_free,
	output apbp_pkg::apbp_ctl_t      ctl
);
	import apbp_pkg::*;

	localparam int MAX_DIG = (NUM_DIG > GAIN_DIGITS) ? NUM_DIG : GAIN_DIGITS;
	localparam int CNT_W   = (MAX_DIG > 1) ? $clog2(MAX_DIG) : 1;
	localparam logic [CNT_W-1:0] MAC_LAST  = CNT_W'(NUM_DIG - 1);
	localparam logic [CNT_W-1:0] GAIN_LAST = CNT_W'(GAIN_DIGITS - 1);

	apbp_state_t      state_q;
	apbp_state_t      state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			ST_IDLE: begin
				cnt_d = '0;
				if (in_fire) begin
					state_d = ST_MAC;
				end
			end
			ST_MAC: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == MAC_LAST) begin
					state_d = ST_BIAS;
				end
			end
			ST_BIAS: begin
				state_d = ST_SAT;
			end
			ST_SAT: begin
				cnt_d   = '0;
				state_d = ST_GAIN;
			end
			ST_GAIN: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == GAIN_LAST) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl = '0;
		case (state_q)
			ST_IDLE: begin
				ctl.idle      = 1'b1;
				ctl.acc_clear = 1'b1;
			end
			ST_MAC: begin
				ctl.mac_step    = 1'b1;
				ctl.first_digit = (cnt_q == '0);
			end
			ST_BIAS: begin
				ctl.bias_add = 1'b1;
			end
			ST_SAT: begin
				ctl.sat_load  = 1'b1;
				ctl.acc_clear = 1'b1;
			end
			ST_GAIN: begin
				ctl.mac_step   = 1'b1;
				ctl.gain_phase = 1'b1;
			end
			ST_OUT: begin
				ctl.out_load = out_free;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/allpass_bandpass_filter.sv =====
// top level of the digit-serial second-order allpass bandpass filter
// a result is registered after the coefficient digit steps, a bias step, a saturate step and the gain digit steps,
// with NUM_DIG = ceil(COEF_WIDTH / 4) digit steps for the coefficient products and 4 for the gain
// the shared digit multiply-accumulate takes a new sample only once the last one is done;
// a waiting result does not block the next transfer in
// reset clears the delay line and coefficients, and sets the gain to one half
`default_nettype none

module allpass_bandpass_filter #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int COEF_WIDTH   = 18
) (
	input  wire logic                                         clk,
	input  wire logic                                         arst_n,
	input  wire logic                                         cfg_we,
	input  wire logic [apbp_pkg::CFG_IDX_W-1:0]               cfg_index,
	input  wire logic [((COEF_WIDTH > apbp_pkg::GAIN_W) ? COEF_WIDTH
	                    : apbp_pkg::GAIN_W)-1:0]              cfg_data,
	input  wire logic                                         sample_in_valid,
	output logic                                              sample_in_stall,
	input  wire logic signed [SAMPLE_WIDTH-1:0]               sample_in,
	output logic                                              sample_out_valid,
	input  wire logic                                         sample_out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]                    sample_out
);
	import apbp_pkg::*;

	localparam int SW      = SAMPLE_WIDTH;
	localparam int CW      = COEF_WIDTH;
	localparam int OP_W    = ((SW > CW) ? SW : CW) + 1;
	localparam int ACC_A   = CW + OP_W + 2;
	localparam int ACC_B   = OP_W + GAIN_W + 2;
	localparam int ACC_AB  = (ACC_A > ACC_B) ? ACC_A : ACC_B;
	localparam int ACC_W   = (ACC_AB > SW + FRAC_BITS + 2) ? ACC_AB : SW + FRAC_BITS + 2;
	localparam int SH_W    = ACC_W - FRAC_BITS;
	localparam int NUM_DIG = (CW + DIGIT_W - 1) / DIGIT_W;
	localparam int CSH_W   = NUM_DIG * DIGIT_W;

	localparam logic signed [CW-1:0] AP_MAX  = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] AP_MIN  = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [SW-1:0] OUT_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] OUT_MIN = {1'b1, {(SW-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) <<< (FRAC_BITS - 1);

	apbp_ctl_t ctl;

	logic signed [CW-1:0]    c_q;
	logic signed [CW-1:0]    k_q;
	logic [GAIN_W-1:0]       gain_q;
	logic signed [SW-1:0]    x1_q;
	logic signed [SW-1:0]    x2_q;
	logic signed [CW-1:0]    y1_q;
	logic signed [CW-1:0]    y2_q;
	logic signed [SW-1:0]    x_q;
	logic signed [OP_W-1:0]  opa_q;
	logic signed [OP_W-1:0]  opb_q;
	logic [CSH_W-1:0]        csh_q;
	logic [CSH_W-1:0]        ksh_q;
	logic [GAIN_W-1:0]       gsh_q;
	logic                    out_valid_q;
	logic signed [SW-1:0]    out_q;

	logic                    in_fire;
	logic                    out_free;
	logic [DIGIT_W-1:0]      digit_a;
	logic [DIGIT_W-1:0]      digit_b;
	logic signed [ACC_W-1:0] bias;
	logic signed [ACC_W-1:0] acc;
	logic signed [SH_W-1:0]  ap_sh;
	logic signed [CW-1:0]    ap_sat;
	logic signed [ACC_W-1:0] out_rnd;
	logic signed [SH_W-1:0]  out_sh;
	logic signed [SW-1:0]    out_sat;

	assign in_fire         = sample_in_valid && ctl.idle;
	assign sample_in_stall = !ctl.idle;
	assign out_free        = !out_valid_q || !sample_out_stall;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q    <= '0;
			k_q    <= '0;
			gain_q <= GAIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_C:    c_q    <= cfg_data[CW-1:0];
				REG_K:    k_q    <= cfg_data[CW-1:0];
				REG_GAIN: gain_q <= cfg_data[GAIN_W-1:0];
				default:  ;
			endcase
		end
	end

	apbp_ctrl #(
		.NUM_DIG (NUM_DIG)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.out_free (out_free),
		.ctl      (ctl)
	);

	// operands and digit shift registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q   <= sample_in;
			opa_q <= OP_W'(y2_q) - OP_W'(sample_in);
			opb_q <= OP_W'(x1_q) - OP_W'(y1_q);
			csh_q <= CSH_W'(c_q);
			ksh_q <= CSH_W'(k_q);
		end else if (ctl.sat_load) begin
			opa_q <= OP_W'(x_q) - OP_W'(ap_sat);
			gsh_q <= gain_q;
		end else if (ctl.mac_step) begin
			if (ctl.gain_phase) begin
				gsh_q <= gsh_q << DIGIT_W;
			end else begin
				csh_q <= csh_q << DIGIT_W;
				ksh_q <= ksh_q << DIGIT_W;
			end
		end
	end

	assign digit_a = ctl.gain_phase ? gsh_q[GAIN_W-1 -: DIGIT_W] : csh_q[CSH_W-1 -: DIGIT_W];
	assign digit_b = ctl.gain_phase ? '0 : ksh_q[CSH_W-1 -: DIGIT_W];

	// x2 at the product scale plus half an lsb for rounding
	assign bias = {{(ACC_W-SW-FRAC_BITS){x2_q[SW-1]}}, x2_q, 1'b1, {(FRAC_BITS-1){1'b0}}};

	apbp_digit_mac #(
		.OP_W  (OP_W),
		.ACC_W (ACC_W)
	) u_mac (
		.clk     (clk),
		.ctl     (ctl),
		.digit_a (digit_a),
		.digit_b (digit_b),
		.op_a    (opa_q),
		.op_b    (opb_q),
		.bias    (bias),
		.acc     (acc)
	);

	// allpass output: shift and saturate
	assign ap_sh = acc[ACC_W-1:FRAC_BITS];
	always_comb begin
		if ((&ap_sh[SH_W-1:CW-1]) || !(|ap_sh[SH_W-1:CW-1])) begin
			ap_sat = ap_sh[CW-1:0];
		end else if (ap_sh[SH_W-1]) begin
			ap_sat = AP_MIN;
		end else begin
			ap_sat = AP_MAX;
		end
	end

	// delay line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= '0;
			x2_q <= '0;
			y1_q <= '0;
			y2_q <= '0;
		end else if (ctl.sat_load) begin
			x2_q <= x1_q;
			x1_q <= x_q;
			y2_q <= y1_q;
			y1_q <= ap_sat;
		end
	end

	// bandpass output: round, shift and saturate
	assign out_rnd = acc + HALF_LSB;
	assign out_sh  = out_rnd[ACC_W-1:FRAC_BITS];
	always_comb begin
		if ((&out_sh[SH_W-1:SW-1]) || !(|out_sh[SH_W-1:SW-1])) begin
			out_sat = out_sh[SW-1:0];
		end else if (out_sh[SH_W-1]) begin
			out_sat = OUT_MIN;
		end else begin
			out_sat = OUT_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!sample_out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_q <= out_sat;
		end
	end

	assign sample_out_valid = out_valid_q;
	assign sample_out       = out_q;

endmodule

`default_nettype wire
